// File: rtl/core/cmc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmc_pkg
// Shared constants and types of the circle mosaic censor.
// ----------------------------------------------------------------------------
package cmc_pkg;

  localparam int unsigned MaxWidthDef  = 64;
  localparam int unsigned MaxHeightDef = 64;
  localparam int unsigned MaxBlockDef  = 16;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 7;
  localparam int unsigned PixW     = 33;

  localparam logic [CfgIdxW-1:0] RegCenterX     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCenterY     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRadius      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBlockWidth  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegImageWidth  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 3'd5;

  localparam logic FuncWrite = 1'b0;
  localparam logic FuncQuery = 1'b1;

  typedef struct packed {
    logic       func;
    logic [5:0] pixel_x;
    logic [5:0] pixel_y;
    logic [8:0] in_hue;
    logic [7:0] in_sat;
    logic [7:0] in_lum;
    logic [7:0] in_alpha;
  } in_word_t;

  typedef struct packed {
    logic [8:0] out_hue;
    logic [7:0] out_sat;
    logic [7:0] out_lum;
    logic [7:0] out_alpha;
    logic       censored;
    logic       bad_coordinate;
  } out_word_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_word_t;

endpackage
`default_nettype wire

// File: rtl/core/cmc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmc_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface cmc_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/cmc_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmc_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cmc_divider import cmc_pkg::*; #(
  parameter int unsigned NumW = 17,
  parameter int unsigned DenW = 13
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 done_o,
  output logic      [NumW-1:0] quot_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quot_q;
  logic [DenW:0]   rem_q;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic [DenW:0]   trial;

  assign trial = {rem_q[DenW-1:0], quot_q[NumW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        quot_q <= num_i;
        rem_q  <= '0;
        den_q  <= den_i;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        if (trial >= {1'b0, den_q}) begin
          rem_q <= trial - {1'b0, den_q};
          quot_q <= {quot_q[NumW-2:0], 1'b1};
        end else begin
          rem_q <= trial;
          quot_q <= {quot_q[NumW-2:0], 1'b0};
        end
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  assign quot_o = quot_q;
endmodule
`default_nettype wire

// File: rtl/core/circle_mosaic_censor_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// circle_mosaic_censor_unit
// Pixel store with circular mosaic censoring on query.
// ----------------------------------------------------------------------------
// One word is taken at a time. A write is stored as it is taken and the next word
// can follow at once. A plain query reads one pixel through the registered
// store port; an out-of-image query skips the read and goes straight to its
// output. A censored query first finds the block corner by repeated compare
// and subtract (one step per block width), then sweeps the clipped block one
// pixel a cycle (up to MAX_BLOCK^2 reads) and runs four channel divisions
// through one shared bit-serial divider. A result waiting in the output
// register does not block writes; the next query stalls at its output. The
// store has no reset; pixels must be written before they are read.
module circle_mosaic_censor_unit import cmc_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef,
  parameter int unsigned MAX_BLOCK  = MaxBlockDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cmc_if.sink       in_if,
  cmc_if.source     out_if,
  cmc_if.sink       cfg_if
);
  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
  localparam int unsigned SumW  = 9 + CntW;

  typedef enum logic [2:0] {
    StIdle, StRead, StBase, StSweep, StDrain, StDiv, StWait, StOut
  } state_e;

  state_e state_q;
  logic [5:0] cx_q, cy_q;
  logic [6:0] rad_q, iw_q, ih_q;
  logic [4:0] bw_q;

  logic [PixW-1:0] mem [Depth];
  logic [PixW-1:0] rdata_q;
  logic [AddrW-1:0] raddr;
  logic [6:0] px_q, py_q, x_q, y_q, x0_q, x1_q, y1_q;
  logic [6:0] rx_q, ry_q;
  logic [SumW-1:0] sum_q [4];
  logic [CntW-1:0] n_q;
  logic [1:0] ch_q;
  logic acc_q, cen_q, bad_q;
  out_word_t res_q;
  logic res_v_q;
  logic [8:0] qv_q [4];

  // effective sizes
  logic [6:0] w_eff, h_eff, bw_eff;
  always_comb begin
    w_eff = (iw_q == 0) ? 7'd1 : ((32'(iw_q) > MAX_WIDTH) ? 7'(MAX_WIDTH) : iw_q);
    h_eff = (ih_q == 0) ? 7'd1 : ((32'(ih_q) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : ih_q);
    bw_eff = (bw_q == 0) ? 7'd1 : ((32'(bw_q) > MAX_BLOCK) ? 7'(MAX_BLOCK) : {2'b0, bw_q});
  end

  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0; cy_q <= '0; rad_q <= '0; bw_q <= 5'd1; iw_q <= 7'd64; ih_q <= 7'd64;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.data.index)
        RegCenterX:     cx_q  <= cfg_if.data.data[5:0];
        RegCenterY:     cy_q  <= cfg_if.data.data[5:0];
        RegRadius:      rad_q <= cfg_if.data.data;
        RegBlockWidth:  bw_q  <= cfg_if.data.data[4:0];
        RegImageWidth:  iw_q  <= cfg_if.data.data;
        RegImageHeight: ih_q  <= cfg_if.data.data;
        default: ;
      endcase
    end
  end

  in_word_t iw;
  assign iw = in_if.data;
  assign in_if.ready = (state_q == StIdle);
  logic in_go;
  assign in_go = in_if.valid && in_if.ready;
  logic in_img;
  assign in_img = ({1'b0, iw.pixel_x} < w_eff) && ({1'b0, iw.pixel_y} < h_eff);

  // store port: write on accepted in-image write, read address from query or sweep position
  assign raddr = AddrW'(32'(y_q) * MAX_WIDTH + 32'(x_q));
  always_ff @(posedge clk_i) begin
    if (in_go && iw.func == FuncWrite && in_img)
      mem[AddrW'(32'(iw.pixel_y) * MAX_WIDTH + 32'(iw.pixel_x))] <=
        {iw.in_alpha, iw.in_lum, iw.in_sat, iw.in_hue};
    rdata_q <= mem[raddr];
  end

  // circle test, one small multiply pair per operand
  logic [6:0] dx, dy;
  logic [13:0] d2, r2;
  assign dx = (px_q > {1'b0, cx_q}) ? px_q - {1'b0, cx_q} : {1'b0, cx_q} - px_q;
  assign dy = (py_q > {1'b0, cy_q}) ? py_q - {1'b0, cy_q} : {1'b0, cy_q} - py_q;
  assign d2 = 14'(dx) * 14'(dx) + 14'(dy) * 14'(dy);
  assign r2 = 14'(rad_q) * 14'(rad_q);

  // block bounds; rx_q/ry_q hold the offset inside the block once reduced
  logic [6:0] bx0, by0, bx1, by1;
  always_comb begin
    bx0 = px_q - rx_q;
    by0 = py_q - ry_q;
    bx1 = (bx0 + bw_eff < w_eff) ? bx0 + bw_eff : w_eff;
    by1 = (by0 + bw_eff < h_eff) ? by0 + bw_eff : h_eff;
  end

  logic div_start, div_done;
  logic [SumW-1:0] div_q;
  cmc_divider #(.NumW(SumW), .DenW(CntW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(sum_q[ch_q]),
    .den_i(n_q), .done_o(div_done), .quot_o(div_q)
  );
  assign div_start = (state_q == StDiv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      res_v_q <= 1'b0;
      acc_q   <= 1'b0;
    end else begin
      if (res_v_q && out_if.ready) res_v_q <= 1'b0;
      unique case (state_q)
        StIdle: if (in_go && iw.func == FuncQuery) begin
          px_q <= {1'b0, iw.pixel_x};
          py_q <= {1'b0, iw.pixel_y};
          x_q  <= {1'b0, iw.pixel_x};
          y_q  <= {1'b0, iw.pixel_y};
          bad_q <= !in_img;
          cen_q <= 1'b0;
          if (!in_img) state_q <= StOut;
          else state_q <= StRead;
        end
        StRead: begin
          // address px,py presented; decide circle membership
          if (d2 <= r2) begin
            rx_q <= px_q;
            ry_q <= py_q;
            state_q <= StBase;
          end else begin
            state_q <= StOut;
          end
        end
        StBase: begin
          // reduce the offsets below the block width, one step a cycle
          if (rx_q >= bw_eff) rx_q <= rx_q - bw_eff;
          if (ry_q >= bw_eff) ry_q <= ry_q - bw_eff;
          if (rx_q < bw_eff && ry_q < bw_eff) begin
            cen_q <= 1'b1;
            x0_q <= bx0; x1_q <= bx1; y1_q <= by1;
            x_q <= bx0; y_q <= by0;
            for (int i = 0; i < 4; i++) sum_q[i] <= '0;
            n_q <= '0;
            acc_q <= 1'b0;
            state_q <= StSweep;
          end
        end
        StSweep: begin
          acc_q <= 1'b1;
          if (x_q + 7'd1 < x1_q) x_q <= x_q + 7'd1;
          else begin
            x_q <= x0_q;
            y_q <= y_q + 7'd1;
          end
          if (!(x_q + 7'd1 < x1_q) && !(y_q + 7'd1 < y1_q)) state_q <= StDrain;
          if (acc_q) begin
            sum_q[0] <= sum_q[0] + SumW'(rdata_q[8:0]);
            sum_q[1] <= sum_q[1] + SumW'(rdata_q[16:9]);
            sum_q[2] <= sum_q[2] + SumW'(rdata_q[24:17]);
            sum_q[3] <= sum_q[3] + SumW'(rdata_q[32:25]);
            n_q <= n_q + 1'b1;
          end
        end
        StDrain: begin
          sum_q[0] <= sum_q[0] + SumW'(rdata_q[8:0]);
          sum_q[1] <= sum_q[1] + SumW'(rdata_q[16:9]);
          sum_q[2] <= sum_q[2] + SumW'(rdata_q[24:17]);
          sum_q[3] <= sum_q[3] + SumW'(rdata_q[32:25]);
          n_q <= n_q + 1'b1;
          ch_q <= '0;
          state_q <= StDiv;
        end
        StDiv: state_q <= StWait;
        StWait: if (div_done) begin
          qv_q[ch_q] <= 9'(div_q);
          if (ch_q == 2'd3) state_q <= StOut;
          else begin
            ch_q <= ch_q + 1'b1;
            state_q <= StDiv;
          end
        end
        StOut: if (!res_v_q) begin
          res_v_q <= 1'b1;
          state_q <= StIdle;
          if (bad_q) res_q <= '{out_hue: '0, out_sat: '0, out_lum: '0, out_alpha: '0,
                                censored: 1'b0, bad_coordinate: 1'b1};
          else if (cen_q) res_q <= '{out_hue: qv_q[0], out_sat: qv_q[1][7:0],
                                     out_lum: qv_q[2][7:0], out_alpha: qv_q[3][7:0],
                                     censored: 1'b1, bad_coordinate: 1'b0};
          else res_q <= '{out_hue: rdata_q[8:0], out_sat: rdata_q[16:9],
                          out_lum: rdata_q[24:17], out_alpha: rdata_q[32:25],
                          censored: 1'b0, bad_coordinate: 1'b0};
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_if.valid = res_v_q;
  assign out_if.data  = res_q;
endmodule
`default_nettype wire
